// File: sv/frame_luma_statistics_unit_assert.svh
// Assertion macros shared by the frame luma statistics checkers.
`ifndef FRAME_LUMA_STATISTICS_UNIT_ASSERT_SVH
`define FRAME_LUMA_STATISTICS_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define FLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define FLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also watches the reset cycles.
`define FLS_ASSERT_ALWAYS_NXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/fls_pkg.sv
// Shared types, constants and helper functions of the frame luma statistics unit.
package fls_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CFG_W       = 11;  // frame size register width
    localparam int DIM_W       = 13;  // clamped frame size, up to 8191
    localparam int LUMA_W      = 8;
    localparam int POS_W       = 10;  // reported row and column width
    localparam int MEAN_W      = 16;
    localparam int DIFF_W      = 9;
    localparam int FRAC_W      = 8;   // fraction bits of the mean
    localparam int LUMA_SHIFT  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int OUT_TDATA_W = 104;
    localparam int IN_TDATA_W  = 24;

    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [LUMA_W-1:0] TARGET_RESET = 8'd255;
    localparam logic [CFG_W-1:0]  DIM_RESET    = 11'd50;
    localparam logic [LUMA_W-1:0] LUMA_TOP     = 8'd255;
    localparam logic [DIFF_W-1:0] DIFF_START   = 9'd256;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    // One classified pixel on its way from the front end to the back end.
    typedef struct packed {
        logic              last;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [LUMA_W-1:0] luma;
    } t_pix;

    typedef struct packed {
        logic idle;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic [POS_W-1:0]  max_row;
        logic [POS_W-1:0]  max_col;
        logic [LUMA_W-1:0] max_level;
        logic [POS_W-1:0]  min_row;
        logic [POS_W-1:0]  min_col;
        logic [LUMA_W-1:0] min_level;
        logic [POS_W-1:0]  near_row;
        logic [POS_W-1:0]  near_col;
        logic [LUMA_W-1:0] near_level;
        logic              exact_found;
    } t_stats;

    typedef struct packed {
        t_stats            stats;
        logic [MEAN_W-1:0] mean_q8;
    } t_result;

    // Zero counts as one, anything above the limit saturates to it.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] ext;
        ext = {{(DIM_W-CFG_W){1'b0}}, v};
        if (ext == '0) begin
            return DIM_W'(1);
        end else if (ext > hi) begin
            return hi;
        end
        return ext;
    endfunction

    // Luma = (3R + 4G + B) >> 3.
    function automatic logic [LUMA_W-1:0] luma_of(input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
        logic [10:0] s;
        s = 11'({r, 1'b0}) + 11'(r) + 11'({g, 2'b00}) + 11'(b);
        return s[LUMA_SHIFT +: LUMA_W];
    endfunction

endpackage

// File: sv/fls_front.sv
// Front end: accepts pixels, computes luma and tracks the raster position.
module fls_front #(
    parameter int MAX_WIDTH  = fls_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fls_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_red,
    input  logic [7:0]                i_green,
    input  logic [7:0]                i_blue,
    input  logic [fls_pkg::DIM_W-1:0] i_width_lim,
    input  logic [fls_pkg::DIM_W-1:0] i_height_lim,
    input  logic                      i_full,
    output logic                      o_push,
    output fls_pkg::t_pix             o_pix
);
    import fls_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          row_end;
    logic          frame_end;
    logic          accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // Classify the pixel: end of row, end of frame.
    assign row_end   = DIM_W'(r_col) >= (i_width_lim - DIM_W'(1));
    assign frame_end = row_end && (DIM_W'(r_row) >= (i_height_lim - DIM_W'(1)));

    // Advance the raster position.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (row_end) begin
            n_col = '0;
            n_row = frame_end ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_push     = accept;
    assign o_pix.last = frame_end;
    assign o_pix.row  = POS_W'(r_row);
    assign o_pix.col  = POS_W'(r_col);
    assign o_pix.luma = luma_of(i_red, i_green, i_blue);

endmodule

// File: sv/fls_queue.sv
// Short pixel queue between the front end and the back end.
module fls_queue #(
    parameter int DEPTH = fls_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fls_pkg::t_pix i_data,
    output logic          o_full,
    output logic          o_valid,
    output fls_pkg::t_pix o_data,
    input  logic          i_pop
);
    import fls_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_pix        r_mem [DEPTH];
    logic [AW:0] r_wr_ptr;
    logic [AW:0] r_rd_ptr;

    assign o_full  = (r_wr_ptr[AW] != r_rd_ptr[AW]) &&
                     (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign o_valid = r_wr_ptr != r_rd_ptr;
    assign o_data  = r_mem[r_rd_ptr[AW-1:0]];

    // Store the entry at the write pointer.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_data;
        end
    end

    // Advance both pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + (AW+1)'(1);
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= r_rd_ptr + (AW+1)'(1);
            end
        end
    end

endmodule

// File: sv/fls_divider.sv
// Bit-serial restoring divider for the frame mean, one quotient bit per cycle.
module fls_divider #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 21
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [NUM_W-1:0]           i_num,
    input  logic [DEN_W-1:0]           i_den,
    input  logic                       i_take,
    output fls_pkg::t_div_stat         o_stat,
    output logic [fls_pkg::MEAN_W-1:0] o_quot
);
    import fls_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    t_div_state       r_state, n_state;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   shifted;
    logic             ge;
    logic [DEN_W:0]   diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign shifted = {r_rem, r_quot[NUM_W-1]};
    assign ge      = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            DIV_IDLE: begin
                if (i_start) n_state = DIV_RUN;
            end
            DIV_RUN: begin
                if (r_cnt == CNT_W'(1)) n_state = DIV_DONE;
            end
            DIV_DONE: begin
                if (i_take) n_state = DIV_IDLE;
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    // Status outputs.
    always_comb begin
        o_stat.idle = 1'b0;
        o_stat.done = 1'b0;
        case (r_state)
            DIV_IDLE: o_stat.idle = 1'b1;
            DIV_DONE: o_stat.done = 1'b1;
            default: begin
                o_stat.idle = 1'b0;
                o_stat.done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Load operands, then iterate over every dividend bit.
    always_ff @(posedge i_clk) begin
        if (r_state == DIV_IDLE && i_start) begin
            r_quot <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_state == DIV_RUN) begin
            r_quot <= {r_quot[NUM_W-2:0], ge};
            r_rem  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    assign o_quot = r_quot[MEAN_W-1:0];

endmodule

// File: sv/fls_back.sv
// Back end: running max, min, nearest and sum, frame result and output register.
module fls_back #(
    parameter int MAX_WIDTH  = fls_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fls_pkg::DEF_MAX_HEIGHT,
    parameter int AREA_W     = 21
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  fls_pkg::t_pix              i_pix,
    output logic                       o_pop,
    input  logic [fls_pkg::LUMA_W-1:0] i_target,
    input  logic [AREA_W-1:0]          i_area,
    output logic                       o_valid,
    input  logic                       i_ready,
    output fls_pkg::t_result           o_result
);
    import fls_pkg::*;

    localparam longint PIX_MAX = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
    localparam int     SUM_W   = $clog2(PIX_MAX * 255 + 1);
    localparam int     NUM_W   = SUM_W + FRAC_W;

    logic [LUMA_W-1:0] r_max, n_max;
    logic [POS_W-1:0]  r_max_row, n_max_row, r_max_col, n_max_col;
    logic [LUMA_W-1:0] r_min, n_min;
    logic [POS_W-1:0]  r_min_row, n_min_row, r_min_col, n_min_col;
    logic [DIFF_W-1:0] r_diff, n_diff;
    logic [LUMA_W-1:0] r_near, n_near;
    logic [POS_W-1:0]  r_near_row, n_near_row, r_near_col, n_near_col;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [LUMA_W-1:0] y;
    logic [LUMA_W-1:0] pix_diff;
    logic              pop;
    logic              frame_done;
    t_stats            r_snap;
    t_result           r_out;
    logic              r_out_valid;
    t_div_stat         div_stat;
    logic [MEAN_W-1:0] div_quot;
    logic              take;

    // Fold the pixel into the running statistics; ties go to the later pixel.
    always_comb begin
        y        = i_pix.luma;
        pix_diff = (y >= i_target) ? (y - i_target) : (i_target - y);

        n_max     = r_max;
        n_max_row = r_max_row;
        n_max_col = r_max_col;
        if (y >= r_max) begin
            n_max     = y;
            n_max_row = i_pix.row;
            n_max_col = i_pix.col;
        end

        n_min     = r_min;
        n_min_row = r_min_row;
        n_min_col = r_min_col;
        if (y <= r_min) begin
            n_min     = y;
            n_min_row = i_pix.row;
            n_min_col = i_pix.col;
        end

        n_diff     = r_diff;
        n_near     = r_near;
        n_near_row = r_near_row;
        n_near_col = r_near_col;
        if (DIFF_W'(pix_diff) <= r_diff) begin
            n_diff     = DIFF_W'(pix_diff);
            n_near     = y;
            n_near_row = i_pix.row;
            n_near_col = i_pix.col;
        end

        n_sum = r_sum + SUM_W'(y);
    end

    // Hold a frame's last pixel until the divider is free.
    assign pop        = i_valid && (!i_pix.last || div_stat.idle);
    assign frame_done = pop && i_pix.last;
    assign o_pop      = pop;

    // Update statistics; clear them after the frame's last pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || frame_done) begin
            r_max      <= '0;
            r_max_row  <= '0;
            r_max_col  <= '0;
            r_min      <= LUMA_TOP;
            r_min_row  <= '0;
            r_min_col  <= '0;
            r_diff     <= DIFF_START;
            r_near     <= '0;
            r_near_row <= '0;
            r_near_col <= '0;
            r_sum      <= '0;
        end else if (pop) begin
            r_max      <= n_max;
            r_max_row  <= n_max_row;
            r_max_col  <= n_max_col;
            r_min      <= n_min;
            r_min_row  <= n_min_row;
            r_min_col  <= n_min_col;
            r_diff     <= n_diff;
            r_near     <= n_near;
            r_near_row <= n_near_row;
            r_near_col <= n_near_col;
            r_sum      <= n_sum;
        end
    end

    // Capture the frame's statistics while the mean is being divided.
    always_ff @(posedge i_clk) begin
        if (frame_done) begin
            r_snap.max_row     <= n_max_row;
            r_snap.max_col     <= n_max_col;
            r_snap.max_level   <= n_max;
            r_snap.min_row     <= n_min_row;
            r_snap.min_col     <= n_min_col;
            r_snap.min_level   <= n_min;
            r_snap.near_row    <= n_near_row;
            r_snap.near_col    <= n_near_col;
            r_snap.near_level  <= n_near;
            r_snap.exact_found <= (n_diff == '0);
        end
    end

    fls_divider #(
        .NUM_W (NUM_W),
        .DEN_W (AREA_W)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (frame_done),
        .i_num   ({n_sum, {FRAC_W{1'b0}}}),
        .i_den   (i_area),
        .i_take  (take),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // Move a finished result into the output register once it is free.
    assign take = div_stat.done && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.stats   <= r_snap;
            r_out.mean_q8 <= div_quot;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// File: sv/frame_luma_statistics_unit.sv
// Frame luma statistics unit: streams RGB pixels, reports per-frame luma extremes,
// nearest-to-target pixel and mean luma.
//
// Pixels enter one per clock in raster order on the s_axis side while the queue has
// room; each pixel's luma (3R+4G+B)>>3 feeds the running maximum, minimum,
// nearest-to-target search and a luma sum, with ties going to the later pixel. On a
// frame's last pixel one result transaction leaves on the m_axis side. The mean is
// computed by a bit-serial restoring divider that produces one quotient bit per cycle
// over the shifted luma sum, $clog2(MAX_WIDTH*MAX_HEIGHT*255+1)+8 bits (36 at the
// default 1024x1024). The result transaction is offered once the frame's last pixel
// has passed through the queue, the divider has finished and the result has moved
// into the output register. Pixels of the next frame keep flowing meanwhile; its last
// pixel waits at the head of the four-entry queue until the divider is free, so while
// the receiver keeps up frames are throttled to one per divider pass, and the input
// stalls once the queue fills behind that pixel. Registers (target_luma at 0x0,
// frame_width at 0x4, frame_height at 0x8) are written over the APB port; the user
// must write them only while the unit is idle, which the unit itself does not
// enforce. Zero sizes count as one and sizes above MAX_WIDTH or MAX_HEIGHT saturate.
module frame_luma_statistics_unit #(
    parameter int MAX_WIDTH  = fls_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fls_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fls_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [fls_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [fls_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // Pixel stream in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: red[7:0], green[15:8], blue[23:16]
    input  logic [fls_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Result stream out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: max_row[9:0], max_col[19:10], max_level[27:20], min_row[37:28],
    // min_col[47:38], min_level[55:48], near_row[65:56], near_col[75:66],
    // near_level[83:76], exact_found[84], mean_q8[100:85], zero[103:101]
    output logic [fls_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import fls_pkg::*;

    localparam longint PIX_MAX = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
    localparam int     AREA_W  = $clog2(PIX_MAX + 1);

    logic [LUMA_W-1:0] r_target;
    logic [CFG_W-1:0]  r_frame_width;
    logic [CFG_W-1:0]  r_frame_height;
    logic [DIM_W-1:0]  width_lim;
    logic [DIM_W-1:0]  height_lim;
    logic [AREA_W-1:0] r_area;
    logic              cfg_write;
    logic              q_full;
    logic              q_push;
    logic              q_valid;
    logic              q_pop;
    t_pix              front_pix;
    t_pix              q_pix;
    t_result           result;

    // Write registers on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target       <= TARGET_RESET;
            r_frame_width  <= DIM_RESET;
            r_frame_height <= DIM_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_TARGET: r_target       <= pwdata[LUMA_W-1:0];
                REG_WIDTH:  r_frame_width  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: r_frame_height <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back registers.
    always_comb begin
        case (paddr[3:2])
            REG_TARGET: prdata = APB_DATA_W'(r_target);
            REG_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            default:    prdata = '0;
        endcase
    end

    // Clamp frame size and register the pixel count for the mean.
    assign width_lim  = clamp_dim(r_frame_width, DIM_W'(MAX_WIDTH));
    assign height_lim = clamp_dim(r_frame_height, DIM_W'(MAX_HEIGHT));

    always_ff @(posedge i_clk) begin
        r_area <= AREA_W'(width_lim) * AREA_W'(height_lim);
    end

    fls_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_red        (s_axis_tdata[7:0]),
        .i_green      (s_axis_tdata[15:8]),
        .i_blue       (s_axis_tdata[23:16]),
        .i_width_lim  (width_lim),
        .i_height_lim (height_lim),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_pix        (front_pix)
    );

    fls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_pix),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_pix),
        .i_pop   (q_pop)
    );

    fls_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AREA_W     (AREA_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_pix    (q_pix),
        .o_pop    (q_pop),
        .i_target (r_target),
        .i_area   (r_area),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    // Pack result fields, first field in the lowest bits.
    assign m_axis_tdata = {3'b000,
                           result.mean_q8,
                           result.stats.exact_found,
                           result.stats.near_level,
                           result.stats.near_col,
                           result.stats.near_row,
                           result.stats.min_level,
                           result.stats.min_col,
                           result.stats.min_row,
                           result.stats.max_level,
                           result.stats.max_col,
                           result.stats.max_row};

endmodule

// File: sv/fls_checker.sv
// Port-level checker for the frame luma statistics unit, bound to the top level.
`include "frame_luma_statistics_unit_assert.svh"

module fls_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fls_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import fls_pkg::*;

    logic [LUMA_W-1:0] max_level;
    logic [LUMA_W-1:0] min_level;
    logic [LUMA_W-1:0] near_level;

    assign max_level  = m_axis_tdata[27:20];
    assign min_level  = m_axis_tdata[55:48];
    assign near_level = m_axis_tdata[83:76];

    // Hold a stalled result transaction.
    `FLS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // Every frame has a pixel, so the maximum never falls below the minimum.
    `FLS_ASSERT_IMP(a_max_ge_min, i_clk, i_rst_n, m_axis_tvalid, max_level >= min_level, "max luma below min luma")

    // The nearest pixel is a real pixel of the frame.
    `FLS_ASSERT_IMP(a_near_in_span, i_clk, i_rst_n, m_axis_tvalid, (near_level >= min_level) && (near_level <= max_level), "nearest luma outside frame range")

    // Drop any pending result on reset.
    `FLS_ASSERT_ALWAYS_NXT(a_reset_idle, i_clk, !i_rst_n, !m_axis_tvalid, "result valid right after reset")

endmodule

bind frame_luma_statistics_unit fls_checker u_fls_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
